### rtl/sfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

  // register map of the configuration port
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER  = 2'd0,
    CFG_MIN_LEN = 2'd1,
    CFG_MAX_LEN = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgDataW = 32;
  localparam int unsigned TotLenW  = 10;

  // register reset values
  localparam logic [31:0]        HeaderReset = 32'h4843_5A4E;
  localparam logic [TotLenW-1:0] MinLenReset = 10'd8;
  localparam logic [TotLenW-1:0] MaxLenReset = 10'd632;

  // header, length field and checksum field together
  localparam logic [15:0] FrameOverhead = 16'd8;
  // bytes in the hunting window
  localparam int unsigned HuntBytes = 4;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_SUM  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_SUM_ERR = 2'd2,
    KIND_LEN_ERR = 2'd3
  } kind_e;

  typedef struct packed {
    logic [31:0]        header_pattern;
    logic [TotLenW-1:0] min_total_length;
    logic [TotLenW-1:0] max_total_length;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/sfd_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module sfd_cfg_regs
  import sfd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  // writes are always taken
  assign cfg_ready_o = 1'b1;

  // decode of the register index; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_HEADER:  cfg_d.header_pattern   = cfg_data_i;
        CFG_MIN_LEN: cfg_d.min_total_length = cfg_data_i[TotLenW-1:0];
        CFG_MAX_LEN: cfg_d.max_total_length = cfg_data_i[TotLenW-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_pattern   <= HeaderReset;
      cfg_q.min_total_length <= MinLenReset;
      cfg_q.max_total_length <= MaxLenReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/sfd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module sfd_parser
  import sfd_pkg::*;
#(
  parameter int unsigned LEN_BITS = 10
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cfg_t                cfg_i,
  input  wire logic                advance_i,
  input  wire logic [7:0]          byte_i,
  output logic                     res_valid_o,
  output kind_e                    res_kind_o,
  output logic [7:0]               res_byte_o,
  output logic [LEN_BITS-1:0]      res_len_o
);

  localparam logic [LEN_BITS-1:0] HuntFull = LEN_BITS'(HuntBytes);

  phase_e              phase_q, phase_d;
  logic [31:0]         win_q, win_d;
  logic [LEN_BITS-1:0] cnt_q, cnt_d;
  logic [LEN_BITS-1:0] plen_q, plen_d;
  logic [15:0]         sum_q, sum_d;
  logic [7:0]          hold_q, hold_d;

  logic [31:0]         win_shift;
  logic [LEN_BITS-1:0] cnt_hunt;
  logic [LEN_BITS-1:0] cnt_inc;
  logic [15:0]         field_val;
  logic [15:0]         sum_add;
  logic [15:0]         win_sum;
  logic [LEN_BITS-1:0] plen_new;
  logic                len_bad;

  // shared datapath terms
  always_comb begin
    win_shift = {win_q[23:0], byte_i};
    cnt_hunt  = (cnt_q < HuntFull) ? cnt_q + 1'b1 : cnt_q;
    cnt_inc   = cnt_q + 1'b1;
    field_val = {byte_i, hold_q};
    sum_add   = sum_q + 16'(byte_i);
    win_sum   = 16'(win_shift[31:24]) + 16'(win_shift[23:16])
              + 16'(win_shift[15:8]) + 16'(win_shift[7:0]);
    plen_new  = LEN_BITS'(field_val - FrameOverhead);
    len_bad   = (field_val < FrameOverhead)
             || (field_val < 16'(cfg_i.min_total_length))
             || (field_val > 16'(cfg_i.max_total_length));
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    win_d   = win_q;
    cnt_d   = cnt_q;
    plen_d  = plen_q;
    sum_d   = sum_q;
    hold_d  = hold_q;
    case (phase_q)
      PH_HUNT: begin
        win_d = win_shift;
        cnt_d = cnt_hunt;
        if (cnt_hunt >= HuntFull && win_shift == cfg_i.header_pattern) begin
          sum_d   = win_sum;
          cnt_d   = '0;
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        sum_d = sum_add;
        if (cnt_q == '0) begin
          hold_d = byte_i;
          cnt_d  = LEN_BITS'(1);
        end else if (len_bad) begin
          phase_d = PH_HUNT;
          win_d   = '0;
          cnt_d   = '0;
        end else begin
          plen_d  = plen_new;
          cnt_d   = '0;
          phase_d = (plen_new == '0) ? PH_SUM : PH_DATA;
        end
      end
      PH_DATA: begin
        sum_d = sum_add;
        cnt_d = cnt_inc;
        if (cnt_inc == plen_q) begin
          cnt_d   = '0;
          phase_d = PH_SUM;
        end
      end
      PH_SUM: begin
        if (cnt_q == '0) begin
          hold_d = byte_i;
          cnt_d  = LEN_BITS'(1);
        end else begin
          phase_d = PH_HUNT;
          win_d   = '0;
          cnt_d   = '0;
        end
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  // result for the byte under work
  always_comb begin
    res_valid_o = 1'b0;
    res_kind_o  = KIND_DATA;
    res_byte_o  = '0;
    res_len_o   = '0;
    case (phase_q)
      PH_LEN: begin
        if (cnt_q != '0 && len_bad) begin
          res_valid_o = 1'b1;
          res_kind_o  = KIND_LEN_ERR;
        end
      end
      PH_DATA: begin
        res_valid_o = 1'b1;
        res_kind_o  = KIND_DATA;
        res_byte_o  = byte_i;
      end
      PH_SUM: begin
        if (cnt_q != '0) begin
          res_valid_o = 1'b1;
          res_kind_o  = (field_val == sum_q) ? KIND_GOOD : KIND_SUM_ERR;
          res_len_o   = plen_q;
        end
      end
      default: res_valid_o = 1'b0;
    endcase
  end

  // frame state, updated once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      win_q   <= '0;
      cnt_q   <= '0;
      plen_q  <= '0;
      sum_q   <= '0;
      hold_q  <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      win_q   <= win_d;
      cnt_q   <= cnt_d;
      plen_q  <= plen_d;
      sum_q   <= sum_d;
      hold_q  <= hold_d;
    end
  end

  // hunting count saturates at the window size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HUNT |-> cnt_q <= HuntFull)
    else $error("hunt count beyond window size");

  // payload position stays below the payload length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> cnt_q < plen_q)
    else $error("payload position overran length");

  // a status result always sends the parser back to hunting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && res_valid_o && res_kind_o != KIND_DATA |=> phase_q == PH_HUNT)
    else $error("status result without return to hunt");

endmodule

`default_nettype wire

### rtl/sfd_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module sfd_out_reg
  import sfd_pkg::*;
#(
  parameter int unsigned LEN_BITS = 10
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire kind_e               kind_i,
  input  wire logic [7:0]          byte_i,
  input  wire logic [LEN_BITS-1:0] len_i,
  output logic                     free_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [1:0]               out_kind_o,
  output logic [7:0]               out_payload_byte_o,
  output logic [LEN_BITS-1:0]      out_payload_len_o
);

  logic                valid_q;
  kind_e               kind_q;
  logic [7:0]          byte_q;
  logic [LEN_BITS-1:0] len_q;

  // room when empty or when the held result leaves this cycle
  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= push_i;
    end
  end

  // payload holds without reset
  always_ff @(posedge clk_i) begin
    if (push_i && free_o) begin
      kind_q <= kind_i;
      byte_q <= byte_i;
      len_q  <= len_i;
    end
  end

  assign out_valid_o        = valid_q;
  assign out_kind_o         = kind_q;
  assign out_payload_byte_o = byte_q;
  assign out_payload_len_o  = len_q;

  // no result is loaded over one that is still stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> free_o)
    else $error("result pushed into full output register");

  // a payload byte result never carries a length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && kind_q == KIND_DATA |-> len_q == '0)
    else $error("payload byte with nonzero length");

endmodule

`default_nettype wire

### rtl/serial_frame_deframer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Frame recovery from a received byte stream.
// Input channel: in_valid_i / in_stall_o with rx_byte_i, one byte per transaction.
// Output channel: out_valid_o / out_stall_i with kind, payload byte and payload
// length. A payload byte gives one result; a frame ends with a good or checksum
// error status, and a bad length field gives a length error status.
// Config channel: cfg_valid_i / cfg_ready_o, index 0 header pattern, 1 minimum
// and 2 maximum total length; ready is always high. Write only while idle.
// Throughput: one byte per cycle unless a result waits on a stalled output, set by
// the frame state update between the input register and the output register.
// A taken byte is registered at the input, and its result in the output register.
// Reset puts the block in header hunting with an empty window and loads the
// register reset values. A stalled output holds its result; the byte in the
// input register then waits only if it makes a result, and the input stalls.
module serial_frame_deframer_core
  import sfd_pkg::*;
#(
  parameter int unsigned LEN_BITS = 10
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [7:0]          rx_byte_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [1:0]               kind_o,
  output logic [7:0]               payload_byte_o,
  output logic [LEN_BITS-1:0]      payload_len_o
);

  cfg_t                cfg;
  logic                in_valid_q;
  logic [7:0]          in_byte_q;
  logic                advance;
  logic                out_free;
  logic                res_valid;
  kind_e               res_kind;
  logic [7:0]          res_byte;
  logic [LEN_BITS-1:0] res_len;

  sfd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // the held byte moves on unless its result finds the output full
  assign advance    = in_valid_q && (!res_valid || out_free);
  assign in_stall_o = in_valid_q && !advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  sfd_parser #(
    .LEN_BITS (LEN_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .advance_i   (advance),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_kind_o  (res_kind),
    .res_byte_o  (res_byte),
    .res_len_o   (res_len)
  );

  sfd_out_reg #(
    .LEN_BITS (LEN_BITS)
  ) u_out (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push_i             (advance && res_valid),
    .kind_i             (res_kind),
    .byte_i             (res_byte),
    .len_i              (res_len),
    .free_o             (out_free),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_kind_o         (kind_o),
    .out_payload_byte_o (payload_byte_o),
    .out_payload_len_o  (payload_len_o)
  );

  // stall only ever comes from a held byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && res_valid && out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

### bench/serial_frame_deframer_core_tb.sv
`timescale 1ns / 1ps

module serial_frame_deframer_core_tb;
  import sfd_pkg::*;

  localparam int unsigned LenBits       = 10;
  localparam int unsigned ResultLatency = 2;
  localparam int unsigned QuietLimit    = 3000;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned PrintCap      = 40;
  // register index with no register behind it
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_CUT} flaw_e;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         data;
    logic [LenBits-1:0] len;
  } deframe_result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] value;
  } reg_write_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [7:0]          rx_byte_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [1:0]          kind_o;
  logic [7:0]          payload_byte_o;
  logic [LenBits-1:0]  payload_len_o;

  serial_frame_deframer_core #(
    .LEN_BITS(LenBits)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .payload_byte_o(payload_byte_o),
    .payload_len_o (payload_len_o)
  );

  // stimulus and expectation stores
  logic [7:0]      rx_stream[$];
  reg_write_t      reg_writes[$];
  deframe_result_t deframed_due[$];

  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_arm = 1'b0;
  bit          hold_used = 1'b0;
  int unsigned hold_left = 0;

  // shadow registers and frame state of the deframer
  logic [31:0]        hdr_pat;
  logic [TotLenW-1:0] min_len;
  logic [TotLenW-1:0] max_len;
  phase_e             ph;
  logic [31:0]        win;
  logic [LenBits-1:0] cnt;
  logic [LenBits-1:0] pay_len;
  logic [15:0]        sum;
  logic [7:0]         low_hold;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (error_count < PrintCap) begin
      $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
    end
    error_count++;
  endtask

  // advance the frame state by one received byte
  task automatic deframe_byte(input logic [7:0] b);
    logic [15:0] field;
    case (ph)
      PH_HUNT: begin
        win = {win[23:0], b};
        if (cnt < HuntBytes) cnt++;
        if (cnt >= HuntBytes && win == hdr_pat) begin
          sum = 16'(win[31:24]) + win[23:16] + win[15:8] + win[7:0];
          cnt = '0;
          ph  = PH_LEN;
        end
      end
      PH_LEN: begin
        sum = sum + b;
        if (cnt == 0) begin
          low_hold = b;
          cnt      = LenBits'(1);
        end else begin
          field = {b, low_hold};
          if (field < FrameOverhead || field < min_len || field > max_len) begin
            ph  = PH_HUNT;
            win = '0;
            cnt = '0;
            deframed_due.push_back('{kind: KIND_LEN_ERR, data: 8'h00, len: '0});
          end else begin
            pay_len = LenBits'(field - FrameOverhead);
            cnt     = '0;
            ph      = (pay_len == 0) ? PH_SUM : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        sum = sum + b;
        cnt++;
        if (cnt == pay_len) begin
          cnt = '0;
          ph  = PH_SUM;
        end
        deframed_due.push_back('{kind: KIND_DATA, data: b, len: '0});
      end
      default: begin
        if (cnt == 0) begin
          low_hold = b;
          cnt      = LenBits'(1);
        end else begin
          field = {b, low_hold};
          ph    = PH_HUNT;
          win   = '0;
          cnt   = '0;
          deframed_due.push_back('{kind: (field == sum) ? KIND_GOOD : KIND_SUM_ERR,
                                   data: 8'h00, len: pay_len});
        end
      end
    endcase
  endtask

  // total length of the next frame, mostly short
  function automatic logic [15:0] pick_total();
    int unsigned span;
    if (min_len > max_len) return 16'($urandom_range(40, 8));
    span = max_len - min_len;
    if (span > 30 && $urandom_range(39) != 0) span = 30;
    return 16'(min_len + $urandom_range(span));
  endfunction

  // whole frame with random payload, optionally damaged
  task automatic queue_frame(input logic [15:0] total, input flaw_e flaw);
    logic [7:0]  bytes_q[$];
    logic [15:0] csum;
    int unsigned keep;
    bytes_q = {hdr_pat[31:24], hdr_pat[23:16], hdr_pat[15:8], hdr_pat[7:0],
               total[7:0], total[15:8]};
    for (int i = 6; i < total - 2; i++) bytes_q.push_back(8'($urandom));
    csum = '0;
    foreach (bytes_q[i]) csum = csum + bytes_q[i];
    if (flaw == FLAW_SUM) csum = csum ^ 16'(1 << $urandom_range(15));
    bytes_q.push_back(csum[7:0]);
    bytes_q.push_back(csum[15:8]);
    keep = bytes_q.size();
    if (flaw == FLAW_CUT) keep = $urandom_range(bytes_q.size() - 1, 5);
    for (int i = 0; i < keep; i++) rx_stream.push_back(bytes_q[i]);
  endtask

  // header followed by a length the block must refuse
  task automatic queue_bad_length();
    logic [15:0] v;
    case ($urandom_range(2))
      0: v = 16'($urandom_range(7));
      1: v = 16'($urandom_range(16'hFFFF, max_len + 1));
      default: v = (min_len > 8) ? 16'($urandom_range(min_len - 1, 8))
                                 : 16'($urandom_range(7));
    endcase
    rx_stream.push_back(hdr_pat[31:24]);
    rx_stream.push_back(hdr_pat[23:16]);
    rx_stream.push_back(hdr_pat[15:8]);
    rx_stream.push_back(hdr_pat[7:0]);
    rx_stream.push_back(v[7:0]);
    rx_stream.push_back(v[15:8]);
  endtask

  // write all registers, the unmapped index too
  task automatic apply_settings(input logic [31:0] hdr, input logic [TotLenW-1:0] lo,
                                input logic [TotLenW-1:0] hi);
    reg_writes.push_back('{idx: CfgIdxSpare, value: $urandom});
    reg_writes.push_back('{idx: CFG_HEADER, value: hdr});
    reg_writes.push_back('{idx: CFG_MIN_LEN, value: {22'($urandom), lo}});
    reg_writes.push_back('{idx: CFG_MAX_LEN, value: {22'($urandom), hi}});
    while (reg_writes.size() != 0 || cfg_valid_i) @(negedge clk_i);
  endtask

  // wait until every byte is taken and every result has come out
  task automatic drain_block();
    while (rx_stream.size() != 0 || in_valid_i || deframed_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (ResultLatency + 2) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [31:0] hdr, input logic [TotLenW-1:0] lo,
                           input logic [TotLenW-1:0] hi, input int unsigned s_idle,
                           input int unsigned r_stall, input int unsigned n_bytes,
                           input bit pressure);
    int unsigned pick;
    apply_settings(hdr, lo, hi);
    sender_idle_pct = s_idle;
    recv_stall_pct  = r_stall;
    hold_arm        = pressure;
    // mostly clean frames, the rest damaged frames and line noise
    while (rx_stream.size() < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 60) queue_frame(pick_total(), FLAW_NONE);
      else if (pick < 70) queue_frame(pick_total(), FLAW_SUM);
      else if (pick < 78) queue_frame(pick_total(), FLAW_CUT);
      else if (pick < 88) queue_bad_length();
      else begin
        if ($urandom_range(1) != 0) rx_stream.push_back(hdr_pat[31:24]);
        repeat ($urandom_range(6, 1)) rx_stream.push_back(8'($urandom));
      end
    end
    drain_block();
    hold_arm = 1'b0;
  endtask

  // register write transactions
  always @(posedge clk_i) begin
    if (rst_ni && (!cfg_valid_i || cfg_ready_o)) begin : cfg_drive
      reg_write_t w;
      if (reg_writes.size() != 0) begin
        w = reg_writes.pop_front();
        cfg_valid_i <= 1'b1;
        cfg_index_i <= w.idx;
        cfg_data_i  <= w.value;
      end else begin
        cfg_valid_i <= 1'b0;
      end
    end
  end

  // byte transactions with random gaps
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (rx_stream.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_valid_i <= 1'b1;
        rx_byte_i  <= rx_stream.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result stalls, with one long hold-off when armed
  always @(posedge clk_i) begin
    if (hold_arm && !hold_used) begin
      hold_left = LongHold;
      hold_used = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // track register writes and bytes, check results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pat  = HeaderReset;
      min_len  = MinLenReset;
      max_len  = MaxLenReset;
      ph       = PH_HUNT;
      win      = '0;
      cnt      = '0;
      pay_len  = '0;
      sum      = '0;
      low_hold = '0;
    end else begin : watch
      deframe_result_t want;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_HEADER:  hdr_pat = cfg_data_i;
          CFG_MIN_LEN: min_len = cfg_data_i[TotLenW-1:0];
          CFG_MAX_LEN: max_len = cfg_data_i[TotLenW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) deframe_byte(rx_byte_i);
      if (out_valid_o && !out_stall_i) begin
        if (deframed_due.size() == 0) begin
          report_mismatch("result with nothing due", kind_o, 16'h0);
        end else begin
          want = deframed_due.pop_front();
          if (kind_o !== want.kind) report_mismatch("kind", kind_o, want.kind);
          if (payload_byte_o !== want.data) begin
            report_mismatch("payload byte", payload_byte_o, want.data);
          end
          if (payload_len_o !== want.len) begin
            report_mismatch("payload length", payload_len_o, want.len);
          end
        end
      end
    end
  end

  // give up when no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("serial_frame_deframer_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [TotLenW-1:0] lo_r;
    logic [TotLenW-1:0] hi_r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // zero header: no match before four bytes, empty payload, short and
    // oversized length fields, bad checksum
    apply_settings(32'h0000_0000, 10'd8, 10'h3FF);
    rx_stream = {8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00,
                 8'h00, 8'h00, 8'h00, 8'h00, 8'h07, 8'h00,
                 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF,
                 8'h00, 8'h00, 8'h00, 8'h00, 8'h09, 8'h00, 8'hFF, 8'h00, 8'h00};
    drain_block();

    run_phase(HeaderReset, MinLenReset, MaxLenReset, 0, 0, 250, 1'b0);
    run_phase($urandom, 10'd8, 10'd40, 65, 0, 250, 1'b0);
    run_phase(32'hFFFF_FFFF, 10'd12, 10'h3FF, 0, 65, 250, 1'b0);
    run_phase($urandom, 10'd8, 10'd8, 34, 34, 250, 1'b0);
    // min above max: every length refused
    run_phase($urandom, 10'h3FF, 10'd8, 0, 0, 200, 1'b0);
    run_phase(HeaderReset, 10'd8, 10'd632, 0, 0, 250, 1'b1);
    lo_r = 10'($urandom_range(64, 8));
    hi_r = 10'($urandom_range(300, lo_r));
    run_phase($urandom, lo_r, hi_r, 34, 34, 250, 1'b0);

    if (error_count == 0) begin
      $display("serial_frame_deframer_core test passed");
    end else begin
      $display("serial_frame_deframer_core test failed");
    end
    $finish;
  end

endmodule
